FILE: hw/rtl/assert_macros.svh
// Assertion macros shared by the block's RTL files.
// Each macro expects clk and arst_n to exist in the module that uses it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

FILE: hw/rtl/bdb_pkg.sv
// Shared constants, codes and types of the brush dab blend unit.
// No dependencies.
package bdb_pkg;

	localparam int MAX_WIDTH = 256;
	localparam int MAX_HEIGHT = 256;
	localparam int MAX_RADIUS = 64;
	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam logic [16:0] Q16_ONE = 17'h10000;

	localparam logic [1:0] OP_WRITE = 2'd0;
	localparam logic [1:0] OP_READ = 2'd1;
	localparam logic [1:0] OP_DAB = 2'd2;
	localparam logic [1:0] OP_UNUSED = 2'd3;

	localparam logic [2:0] REG_RED = 3'd0;
	localparam logic [2:0] REG_GREEN = 3'd1;
	localparam logic [2:0] REG_BLUE = 3'd2;
	localparam logic [2:0] REG_ALPHA = 3'd3;
	localparam logic [2:0] REG_RADIUS = 3'd4;
	localparam logic [2:0] REG_STRENGTH = 3'd5;
	localparam logic [2:0] REG_WIDTH = 3'd6;
	localparam logic [2:0] REG_HEIGHT = 3'd7;

	typedef struct packed {
		logic start;
		logic [11:0] d2;
		logic [6:0] radius;
		logic [16:0] k;
	} weight_req_t;

	typedef struct packed {
		logic done;
		logic [16:0] w;
	} weight_rsp_t;

endpackage

FILE: hw/rtl/bdb_ram.sv
// Generic single-port synchronous RAM with a registered read.
// No dependencies.
module bdb_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] addr,
	input logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

FILE: hw/rtl/bdb_weight.sv
// Iterative weight unit: square root, division by the radius, two smoothsteps, scaling.
// Depends on bdb_pkg and assert_macros.svh.
`include "assert_macros.svh"
module bdb_weight (
	input logic clk,
	input logic arst_n,
	input bdb_pkg::weight_req_t req,
	output bdb_pkg::weight_rsp_t rsp
);

	localparam logic [2:0] W_IDLE = 3'd0;
	localparam logic [2:0] W_SQRT = 3'd1;
	localparam logic [2:0] W_DIV = 3'd2;
	localparam logic [2:0] W_SQ = 3'd3;
	localparam logic [2:0] W_MUL = 3'd4;
	localparam logic [2:0] W_KS = 3'd5;

	logic [2:0] st_q;
	logic [4:0] cnt_q;
	logic [43:0] v_q, rt_q, b_q;
	logic [6:0] rem_q, r_q;
	logic [21:0] num_q;
	logic [16:0] w_q, k_q;
	logic [33:0] sq_q;
	logic [17:0] t_q;
	logic pass_q, done_q;

	logic [43:0] sum, v_nxt, rt_nxt;
	logic [7:0] trial;
	logic ge;
	logic [6:0] rem_nxt;
	logic [21:0] num_nxt;
	logic [51:0] prod;
	logic [33:0] prod_k;

	always_comb begin
		sum = rt_q + b_q;
		if (v_q >= sum) begin
			v_nxt = v_q - sum;
			rt_nxt = (rt_q >> 1) + b_q;
		end else begin
			v_nxt = v_q;
			rt_nxt = rt_q >> 1;
		end
		trial = {rem_q, num_q[21]};
		ge = trial >= {1'b0, r_q};
		rem_nxt = ge ? 7'(trial - {1'b0, r_q}) : trial[6:0];
		num_nxt = {num_q[20:0], ge};
		prod = 52'(sq_q) * 52'(t_q);
		prod_k = 34'(w_q) * 34'(k_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= W_IDLE;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (st_q)
				W_IDLE: begin
					if (req.start) begin
						st_q <= W_SQRT;
					end
				end
				W_SQRT: begin
					if (cnt_q == 5'd0) begin
						st_q <= W_DIV;
					end
				end
				W_DIV: begin
					if (cnt_q == 5'd0) begin
						st_q <= W_SQ;
					end
				end
				W_SQ: st_q <= W_MUL;
				W_MUL: st_q <= pass_q ? W_KS : W_SQ;
				W_KS: begin
					st_q <= W_IDLE;
					done_q <= 1'b1;
				end
				default: st_q <= W_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			W_IDLE: begin
				v_q <= {req.d2, 32'd0};
				rt_q <= '0;
				b_q <= 44'd1 << 42;
				cnt_q <= 5'd21;
				r_q <= req.radius;
				k_q <= req.k;
			end
			W_SQRT: begin
				v_q <= v_nxt;
				rt_q <= rt_nxt;
				b_q <= b_q >> 2;
				if (cnt_q == 5'd0) begin
					num_q <= rt_nxt[21:0];
					rem_q <= '0;
					cnt_q <= 5'd21;
				end else begin
					cnt_q <= cnt_q - 5'd1;
				end
			end
			W_DIV: begin
				rem_q <= rem_nxt;
				num_q <= num_nxt;
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd0) begin
					w_q <= 17'(18'h10000 - {2'b0, num_nxt[15:0]});
					pass_q <= 1'b0;
				end
			end
			W_SQ: begin
				sq_q <= 34'(w_q) * 34'(w_q);
				t_q <= 18'd196608 - {w_q, 1'b0};
			end
			W_MUL: begin
				w_q <= prod[48:32];
				pass_q <= 1'b1;
			end
			W_KS: begin
				w_q <= prod_k[32:16];
			end
			default: begin
			end
		endcase
	end

	assign rsp.done = done_q;
	assign rsp.w = w_q;

	`ASSERT_IMP(a_start_idle, req.start, st_q == W_IDLE)
	`ASSERT_NXT(a_done_after_ks, st_q == W_KS, done_q)
	`ASSERT_NXT(a_div_after_sqrt, (st_q == W_SQRT) && (cnt_q == 5'd0), st_q == W_DIV)

endmodule

FILE: hw/rtl/brush_dab_blend_unit.sv
// Brush dab blend unit: a 256x256 RGBA8 frame store with pixel write, pixel read
// and a circular soft brush dab. One request on s_*, one result on m_* per request.
// Depends on bdb_pkg, bdb_ram, bdb_weight and assert_macros.svh.
//
// Usage: a request carries op in s_tuser and position, pixel and pressure in s_tdata.
// Configuration must be written on cfg_we/cfg_index/cfg_data only while the unit
// is idle; the unit itself does not enforce this. An accepted write passes S_EXEC,
// a read S_EXEC and, on the image, S_RD_DATA, and a dab S_EXEC, S_P2, S_K and,
// for a nonzero radius, the scan, before S_FINISH.
// A dab walks all (2r+1)^2 offsets; S_SCAN skips each offset outside the circle
// or the image, and each blended pixel waits for the bit-serial square root and
// division in the weight unit (22 steps each) and the frame store read/write.
// One request is processed at a time; the next request is taken once the result
// has moved into the output register, even while the receiver stalls it there.
// m_tvalid holds with stable data until m_tready is high.
// Reset restores the configuration defaults and empties the output register;
// the frame store is not cleared and holds undefined data until written.
`include "assert_macros.svh"
module brush_dab_blend_unit (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	output logic s_tready,
	// pos_x[9:0], pos_y[19:10], pixel_word[51:20], pen_pressure[68:52], zero fill.
	input logic [71:0] s_tdata,
	// op[1:0].
	input logic [1:0] s_tuser,
	output logic m_tvalid,
	input logic m_tready,
	// read_word[31:0], touched_count[46:32], zero fill.
	output logic [47:0] m_tdata,
	input logic cfg_we,
	input logic [2:0] cfg_index,
	input logic [16:0] cfg_data
);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_EXEC = 4'd1;
	localparam logic [3:0] S_RD_DATA = 4'd2;
	localparam logic [3:0] S_P2 = 4'd3;
	localparam logic [3:0] S_K = 4'd4;
	localparam logic [3:0] S_SCAN = 4'd5;
	localparam logic [3:0] S_WAIT = 4'd6;
	localparam logic [3:0] S_MEM_RD = 4'd7;
	localparam logic [3:0] S_BLEND = 4'd8;
	localparam logic [3:0] S_FINISH = 4'd9;
	localparam int AW = bdb_pkg::ADDR_W;

	logic [7:0] red_q, green_q, blue_q, alpha_q;
	logic [6:0] radius_q;
	logic [16:0] strength_q;
	logic [8:0] width_q, height_q;

	logic [3:0] state_q;
	logic [1:0] op_q;
	logic [9:0] px_q, py_q;
	logic [31:0] pix_q;
	logic [16:0] press_q;
	logic [16:0] p2_q, k_q, w_q;
	logic [7:0] i_q, j_q, ix_q, iy_q;
	logic [AW-1:0] addr_q;
	logic [14:0] cnt_q;
	logic [31:0] word_q;
	logic [31:0] out_word_q;
	logic [14:0] out_cnt_q;
	logic out_valid_q;

	logic [8:0] wd, ht;
	logic [6:0] r;
	logic [16:0] p_sat, s_sat;
	logic on_img;
	logic [7:0] ai, aj;
	logic [13:0] d2;
	logic [12:0] rr;
	logic [10:0] ix, iy;
	logic in_circle, last_j, last_i;
	logic [7:0] ax, ay;
	logic [AW-1:0] calc_addr;
	logic [33:0] p_prod, k_prod;
	logic [31:0] blend_word;
	logic [31:0] brush_word;
	logic [24:0] chan_sum;
	logic mem_we;
	logic [AW-1:0] mem_addr;
	logic [31:0] mem_wdata, mem_rdata;
	bdb_pkg::weight_req_t wreq;
	bdb_pkg::weight_rsp_t wrsp;

	always_comb begin
		wd = (width_q == 9'd0) ? 9'd1 :
			(width_q > 9'(bdb_pkg::MAX_WIDTH)) ? 9'(bdb_pkg::MAX_WIDTH) : width_q;
		ht = (height_q == 9'd0) ? 9'd1 :
			(height_q > 9'(bdb_pkg::MAX_HEIGHT)) ? 9'(bdb_pkg::MAX_HEIGHT) : height_q;
		r = (radius_q > 7'(bdb_pkg::MAX_RADIUS)) ? 7'(bdb_pkg::MAX_RADIUS) : radius_q;
		p_sat = (press_q > bdb_pkg::Q16_ONE) ? bdb_pkg::Q16_ONE : press_q;
		s_sat = (strength_q > bdb_pkg::Q16_ONE) ? bdb_pkg::Q16_ONE : strength_q;
		on_img = !px_q[9] && !py_q[9] && (px_q[8:0] < wd) && (py_q[8:0] < ht);

		ai = i_q[7] ? 8'(-i_q) : i_q;
		aj = j_q[7] ? 8'(-j_q) : j_q;
		d2 = 14'(ai[6:0]) * 14'(ai[6:0]) + 14'(aj[6:0]) * 14'(aj[6:0]);
		rr = 13'(r) * 13'(r);
		ix = {px_q[9], px_q} + {{3{i_q[7]}}, i_q};
		iy = {py_q[9], py_q} + {{3{j_q[7]}}, j_q};
		in_circle = ({1'b0, d2[12:0]} < {1'b0, rr}) && !d2[13] && !ix[10] && !iy[10]
			&& (ix[9:0] < {1'b0, wd}) && (iy[9:0] < {1'b0, ht});
		last_j = j_q == {1'b0, r};
		last_i = i_q == {1'b0, r};

		ax = (state_q == S_EXEC) ? px_q[7:0] : ix_q;
		ay = (state_q == S_EXEC) ? py_q[7:0] : iy_q;
		calc_addr = AW'(17'(ay) * 17'(wd) + 17'(ax));

		p_prod = 34'(p_sat) * 34'(p_sat);
		k_prod = 34'(s_sat) * 34'(p2_q);

		brush_word = {alpha_q, blue_q, green_q, red_q};
		for (int c = 0; c < 4; c++) begin
			chan_sum = 25'(mem_rdata[c*8 +: 8]) * 25'(bdb_pkg::Q16_ONE - w_q)
				+ 25'(brush_word[c*8 +: 8]) * 25'(w_q);
			blend_word[c*8 +: 8] = chan_sum[23:16];
		end

		wreq.start = (state_q == S_SCAN) && in_circle;
		wreq.d2 = d2[11:0];
		wreq.radius = r;
		wreq.k = k_q;

		mem_we = ((state_q == S_EXEC) && (op_q == bdb_pkg::OP_WRITE) && on_img)
			|| (state_q == S_BLEND);
		mem_addr = (state_q == S_BLEND) ? addr_q : calc_addr;
		mem_wdata = (state_q == S_BLEND) ? blend_word : pix_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			red_q <= 8'd0;
			green_q <= 8'd0;
			blue_q <= 8'd0;
			alpha_q <= 8'd255;
			radius_q <= 7'd25;
			strength_q <= 17'h10000;
			width_q <= 9'd256;
			height_q <= 9'd256;
		end else if (cfg_we) begin
			case (cfg_index)
				bdb_pkg::REG_RED: red_q <= cfg_data[7:0];
				bdb_pkg::REG_GREEN: green_q <= cfg_data[7:0];
				bdb_pkg::REG_BLUE: blue_q <= cfg_data[7:0];
				bdb_pkg::REG_ALPHA: alpha_q <= cfg_data[7:0];
				bdb_pkg::REG_RADIUS: radius_q <= cfg_data[6:0];
				bdb_pkg::REG_STRENGTH: strength_q <= cfg_data;
				bdb_pkg::REG_WIDTH: width_q <= cfg_data[8:0];
				bdb_pkg::REG_HEIGHT: height_q <= cfg_data[8:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if ((state_q == S_FINISH) && (!out_valid_q || m_tready)) begin
				out_valid_q <= 1'b1;
			end else if (m_tvalid && m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					case (op_q)
						bdb_pkg::OP_READ: state_q <= on_img ? S_RD_DATA : S_FINISH;
						bdb_pkg::OP_DAB: state_q <= S_P2;
						default: state_q <= S_FINISH;
					endcase
				end
				S_RD_DATA: state_q <= S_FINISH;
				S_P2: state_q <= S_K;
				S_K: state_q <= (r == 7'd0) ? S_FINISH : S_SCAN;
				S_SCAN: begin
					if (in_circle) begin
						state_q <= S_WAIT;
					end else if (last_i && last_j) begin
						state_q <= S_FINISH;
					end
				end
				S_WAIT: begin
					if (wrsp.done) begin
						state_q <= S_MEM_RD;
					end
				end
				S_MEM_RD: state_q <= S_BLEND;
				S_BLEND: state_q <= (last_i && last_j) ? S_FINISH : S_SCAN;
				S_FINISH: begin
					if (!out_valid_q || m_tready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				op_q <= s_tuser;
				px_q <= s_tdata[9:0];
				py_q <= s_tdata[19:10];
				pix_q <= s_tdata[51:20];
				press_q <= s_tdata[68:52];
				word_q <= '0;
				cnt_q <= '0;
			end
			S_RD_DATA: word_q <= mem_rdata;
			S_P2: p2_q <= p_prod[32:16];
			S_K: begin
				k_q <= k_prod[32:16];
				i_q <= -{1'b0, r};
				j_q <= -{1'b0, r};
			end
			S_SCAN: begin
				ix_q <= ix[7:0];
				iy_q <= iy[7:0];
				if (!in_circle) begin
					if (last_j) begin
						i_q <= i_q + 8'd1;
						j_q <= -{1'b0, r};
					end else begin
						j_q <= j_q + 8'd1;
					end
				end
			end
			S_WAIT: w_q <= wrsp.w;
			S_MEM_RD: addr_q <= calc_addr;
			S_BLEND: begin
				cnt_q <= cnt_q + 15'd1;
				if (last_j) begin
					i_q <= i_q + 8'd1;
					j_q <= -{1'b0, r};
				end else begin
					j_q <= j_q + 8'd1;
				end
			end
			S_FINISH: begin
				if (!out_valid_q || m_tready) begin
					out_word_q <= word_q;
					out_cnt_q <= cnt_q;
				end
			end
			default: begin
			end
		endcase
	end

	bdb_ram #(
		.WIDTH(32),
		.DEPTH(bdb_pkg::DEPTH)
	) u_frame (
		.clk(clk),
		.we(mem_we),
		.addr(mem_addr),
		.wdata(mem_wdata),
		.rdata(mem_rdata)
	);

	bdb_weight u_weight (
		.clk(clk),
		.arst_n(arst_n),
		.req(wreq),
		.rsp(wrsp)
	);

	assign s_tready = state_q == S_IDLE;
	assign m_tvalid = out_valid_q;
	assign m_tdata = {1'b0, out_cnt_q, out_word_q};

	`ASSERT_IMP(a_done_in_wait, wrsp.done, state_q == S_WAIT)
	`ASSERT_IMP(a_blend_after_read, state_q == S_BLEND, $past(state_q) == S_MEM_RD)
	`ASSERT_NXT(a_accept_exec, s_tvalid && s_tready, state_q == S_EXEC)

endmodule
